// File: src/dtm_pkg.sv
package dtm_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_YEAR   = 3'd1,
    ST_MONTH  = 3'd2,
    ST_DAY    = 3'd3,
    ST_HOUR   = 3'd4,
    ST_MINUTE = 3'd5,
    ST_SECOND = 3'd6
  } status_e;

  localparam int unsigned EpochW = 41;
  localparam int unsigned TotalW = 42;

  localparam logic [19:0]        UsMax         = 20'd999999;
  localparam logic signed [15:0] CenturyBase   = 16'sd1900;
  localparam logic signed [15:0] PivotYear     = 16'sd50;
  localparam logic signed [15:0] CenturyLen    = 16'sd100;
  localparam logic signed [15:0] YearMin       = 16'sd1;
  localparam logic signed [15:0] YearMax       = 16'sd200;
  localparam logic signed [17:0] DayBase       = 18'sd36525;
  localparam logic signed [34:0] SecPerDay     = 35'sd86400;
  localparam logic signed [41:0] HalfDayOffset = 42'sd2894400;

  // Input transaction
  typedef struct packed {
    logic [13:0] year_value;
    logic        four_digit_year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [19:0] microsecond;
  } dtm_in_t;

  // Output transaction
  typedef struct packed {
    logic signed [41:0] total_seconds;
    logic [19:0]        sub_second;
    status_e            status;
  } dtm_out_t;

  // After range checks and month shift
  typedef struct packed {
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] us;
    status_e     status;
  } dtm_s1_t;

  // After day count and time of day
  typedef struct packed {
    logic signed [16:0] days;
    logic [16:0]        tod;
    logic [19:0]        us;
    status_e            status;
  } dtm_s2_t;

  // After scaling days to seconds
  typedef struct packed {
    logic signed [34:0] scaled;
    logic [16:0]        tod;
    logic [19:0]        us;
    status_e            status;
  } dtm_s3_t;

  // Days in month, February always 29
  function automatic logic [4:0] month_len(input logic [6:0] m);
    logic [4:0] len;
    len = 5'd31;
    if (m == 7'd2) begin
      len = 5'd29;
    end else if (m == 7'd4 || m == 7'd6 || m == 7'd9 || m == 7'd11) begin
      len = 5'd30;
    end
    return len;
  endfunction

  // floor(3(m+1)/5) for shifted months 3 to 14
  function automatic logic [3:0] month_frac(input logic [3:0] m);
    logic [3:0] f;
    unique case (m)
      4'd3:    f = 4'd2;
      4'd4:    f = 4'd3;
      4'd5:    f = 4'd3;
      4'd6:    f = 4'd4;
      4'd7:    f = 4'd4;
      4'd8:    f = 4'd5;
      4'd9:    f = 4'd6;
      4'd10:   f = 4'd6;
      4'd11:   f = 4'd7;
      4'd12:   f = 4'd7;
      4'd13:   f = 4'd8;
      4'd14:   f = 4'd9;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

endpackage

// File: src/dtm_chan_if.sv
interface dtm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/datetime_to_mjd_seconds.sv
// Date-time to modified Julian time in seconds.
//
// in_ch carries one parsed local date-time per transaction (year digits,
// four-digit flag, month, day, hour, minute, second, microseconds).
// out_ch returns one result per input: signed whole seconds, microseconds
// and a status code (nonzero on the first failed range check, with the
// time fields forced to zero). cfg_ch writes the 41-bit signed epoch
// offset in seconds; it is always ready and should be written only while
// no transaction is in flight.
//
// Four register stages: range check, day count, multiply by 86400, final
// add. One transaction is taken per cycle unless a stalled out_ch has
// filled the pipe. Each stage holds its own valid bit, so a stalled out_ch
// fills the pipe stage by stage; in_ch.ready drops only when all four
// stages hold data. Bubbles close up while stalled.
//
// Reset clears all valid bits and sets the epoch offset to zero.
module datetime_to_mjd_seconds (
  input  logic clk_i,
  input  logic rst_ni,
  dtm_chan_if.sink   in_ch,
  dtm_chan_if.sink   cfg_ch,
  dtm_chan_if.source out_ch
);

  logic signed [40:0] epoch_q;
  logic               s1_valid, s1_ready;
  logic               s2_valid, s2_ready;
  dtm_pkg::dtm_s1_t   s1_data;
  dtm_pkg::dtm_s2_t   s2_data;

  // Hold the epoch offset
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0;
    end else if (cfg_ch.valid) begin
      epoch_q <= cfg_ch.payload;
    end
  end

  dtm_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .in_data_i   (in_ch.payload),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .out_data_o  (s1_data)
  );

  dtm_daycount u_daycount (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_data_i   (s1_data),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .out_data_o  (s2_data)
  );

  dtm_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .epoch_i     (epoch_q),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .in_data_i   (s2_data),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_o  (out_ch.payload)
  );

  // An empty output stage never blocks the input
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output stage");

  // Error results carry zero time fields
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.payload.status != dtm_pkg::ST_OK
      |-> out_ch.payload.total_seconds == '0 && out_ch.payload.sub_second == '0)
    else $error("error result with nonzero time");

  // Microseconds stay clamped
  a_us_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.payload.sub_second <= dtm_pkg::UsMax)
    else $error("sub_second above limit");

  // A full pipe with a stalled sink takes nothing new
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready && !in_ch.ready |=> out_ch.valid)
    else $error("result lost under stall");

endmodule

// File: src/dtm_check.sv
module dtm_check (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dtm_pkg::dtm_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dtm_pkg::dtm_s1_t out_data_o
);

  logic               valid_q;
  dtm_pkg::dtm_s1_t   data_q, data_d;
  logic signed [15:0] year_sub, year_adj;
  logic               early;
  dtm_pkg::status_e   status;

  // Adjust the year: drop the century, wrap years below the pivot
  always_comb begin
    year_sub = signed'({2'b00, in_data_i.year_value});
    if (in_data_i.four_digit_year) begin
      year_sub = year_sub - dtm_pkg::CenturyBase;
    end
    year_adj = year_sub;
    if (year_sub < dtm_pkg::PivotYear) begin
      year_adj = year_sub + dtm_pkg::CenturyLen;
    end
  end

  // Range checks, first failure wins
  always_comb begin
    priority if (year_adj < dtm_pkg::YearMin || year_adj > dtm_pkg::YearMax) begin
      status = dtm_pkg::ST_YEAR;
    end else if (in_data_i.month < 7'd1 || in_data_i.month > 7'd12) begin
      status = dtm_pkg::ST_MONTH;
    end else if (in_data_i.day < 7'd1 ||
                 in_data_i.day > {2'b00, dtm_pkg::month_len(in_data_i.month)}) begin
      status = dtm_pkg::ST_DAY;
    end else if (in_data_i.hour > 7'd23) begin
      status = dtm_pkg::ST_HOUR;
    end else if (in_data_i.minute > 7'd59) begin
      status = dtm_pkg::ST_MINUTE;
    end else if (in_data_i.second > 7'd59) begin
      status = dtm_pkg::ST_SECOND;
    end else begin
      status = dtm_pkg::ST_OK;
    end
  end

  // Move January and February to the end of the previous year
  always_comb begin
    early          = in_data_i.month < 7'd3;
    data_d.year    = year_adj[7:0] - {7'd0, early};
    data_d.month   = early ? in_data_i.month[3:0] + 4'd12 : in_data_i.month[3:0];
    data_d.day     = in_data_i.day[4:0];
    data_d.hour    = in_data_i.hour[4:0];
    data_d.minute  = in_data_i.minute[5:0];
    data_d.second  = in_data_i.second[5:0];
    data_d.us      = (in_data_i.microsecond > dtm_pkg::UsMax) ? dtm_pkg::UsMax
                                                               : in_data_i.microsecond;
    data_d.status  = status;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Advance the stage when the next one takes the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: src/dtm_daycount.sv
module dtm_daycount (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dtm_pkg::dtm_s1_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dtm_pkg::dtm_s2_t out_data_o
);

  logic               valid_q;
  dtm_pkg::dtm_s2_t   data_q, data_d;
  logic [16:0]        day_sum;
  logic signed [17:0] day_diff;

  // Count days from the calendar fields, then take the time of day
  always_comb begin
    day_sum = 17'(in_data_i.year) * 17'd365
            + 17'(in_data_i.month) * 17'd30
            + 17'(in_data_i.day)
            + 17'(dtm_pkg::month_frac(in_data_i.month))
            + 17'(in_data_i.year[7:2]);
    day_diff = signed'({1'b0, day_sum}) - dtm_pkg::DayBase;
    data_d.days   = day_diff[16:0];
    data_d.tod    = 17'(in_data_i.hour) * 17'd3600
                  + 17'(in_data_i.minute) * 17'd60
                  + 17'(in_data_i.second);
    data_d.us     = in_data_i.us;
    data_d.status = in_data_i.status;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: src/dtm_scale.sv
module dtm_scale (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [40:0]       epoch_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  dtm_pkg::dtm_s2_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output dtm_pkg::dtm_out_t        out_data_o
);

  logic               mul_valid_q, sum_valid_q;
  logic               mul_ready, sum_ready;
  dtm_pkg::dtm_s3_t   mul_q, mul_d;
  dtm_pkg::dtm_out_t  sum_q, sum_d;
  logic signed [41:0] total;

  // Scale days to seconds
  always_comb begin
    mul_d.scaled = 35'(in_data_i.days) * dtm_pkg::SecPerDay;
    mul_d.tod    = in_data_i.tod;
    mul_d.us     = in_data_i.us;
    mul_d.status = in_data_i.status;
  end

  // Add time of day and epoch offset; zero the result on error
  always_comb begin
    total = 42'(mul_q.scaled) - dtm_pkg::HalfDayOffset
          + signed'({25'd0, mul_q.tod}) + 42'(epoch_i);
    if (mul_q.status == dtm_pkg::ST_OK) begin
      sum_d.total_seconds = total;
      sum_d.sub_second    = mul_q.us;
    end else begin
      sum_d.total_seconds = '0;
      sum_d.sub_second    = '0;
    end
    sum_d.status = mul_q.status;
  end

  assign sum_ready   = !sum_valid_q || out_ready_i;
  assign mul_ready   = !mul_valid_q || sum_ready;
  assign in_ready_o  = mul_ready;
  assign out_valid_o = sum_valid_q;
  assign out_data_o  = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_valid_q <= in_valid_i;
      end
      if (sum_ready) begin
        sum_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && in_valid_i) begin
      mul_q <= mul_d;
    end
    if (sum_ready && mul_valid_q) begin
      sum_q <= sum_d;
    end
  end

endmodule

// File: bench/testbench.sv
module testbench;

  typedef logic [dtm_pkg::EpochW-1:0] epoch_t;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;

  dtm_chan_if #(.T(dtm_pkg::dtm_in_t))  in_ch ();
  dtm_chan_if #(.T(epoch_t))            cfg_ch ();
  dtm_chan_if #(.T(dtm_pkg::dtm_out_t)) out_ch ();

  datetime_to_mjd_seconds dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // Shadow of the epoch register and the results still owed by the block
  longint              epoch_offset;
  dtm_pkg::dtm_out_t   owed_mjd_results[$];
  int unsigned         mismatches;
  int unsigned         cycle_count;
  bit                  idle_on;
  int unsigned         long_hold;
  int unsigned         stall_left;

  always #6 clk_i = ~clk_i;

  // Expected conversion of one date-time to modified Julian seconds
  function automatic dtm_pkg::dtm_out_t mjd_of(dtm_pkg::dtm_in_t t);
    longint             y, mo, dd, hh, mi, ss, days, total;
    int                 mlen;
    logic [19:0]        us;
    dtm_pkg::status_e   st;
    dtm_pkg::dtm_out_t  r;
    y  = t.year_value;
    mo = t.month;
    dd = t.day;
    hh = t.hour;
    mi = t.minute;
    ss = t.second;
    if (t.four_digit_year) y = y - 1900;
    if (y < 50) y = y + 100;
    us = (t.microsecond > 20'd999999) ? 20'd999999 : t.microsecond;
    case (mo)
      2:          mlen = 29;
      4, 6, 9, 11: mlen = 30;
      default:    mlen = 31;
    endcase
    st = dtm_pkg::ST_OK;
    if (y < 1 || y > 200) begin
      st = dtm_pkg::ST_YEAR;
    end else if (mo < 1 || mo > 12) begin
      st = dtm_pkg::ST_MONTH;
    end else if (dd < 1 || dd > mlen) begin
      st = dtm_pkg::ST_DAY;
    end else if (hh > 23) begin
      st = dtm_pkg::ST_HOUR;
    end else if (mi > 59) begin
      st = dtm_pkg::ST_MINUTE;
    end else if (ss > 59) begin
      st = dtm_pkg::ST_SECOND;
    end
    r = '0;
    r.status = st;
    if (st == dtm_pkg::ST_OK) begin
      // January and February belong to the previous year
      if (mo < 3) begin
        mo = mo + 12;
        y  = y - 1;
      end
      days  = 365 * y + 30 * mo + dd + (3 * (mo + 1)) / 5 + y / 4 - 36525;
      total = days * 86400 - 2894400 + (hh * 60 + mi) * 60 + ss + epoch_offset;
      r.total_seconds = total[41:0];
      r.sub_second    = us;
    end
    return r;
  endfunction

  function automatic dtm_pkg::dtm_in_t date_time(int unsigned y, bit four, int unsigned mo,
                                                 int unsigned dd, int unsigned hh,
                                                 int unsigned mi, int unsigned ss,
                                                 int unsigned us);
    dtm_pkg::dtm_in_t t;
    t.year_value      = 14'(y);
    t.four_digit_year = four;
    t.month           = 7'(mo);
    t.day             = 7'(dd);
    t.hour            = 7'(hh);
    t.minute          = 7'(mi);
    t.second          = 7'(ss);
    t.microsecond     = 20'(us);
    return t;
  endfunction

  // Plausible date-time, or one with a field thrown anywhere in its width
  function automatic dtm_pkg::dtm_in_t random_date_time(bit well_formed);
    dtm_pkg::dtm_in_t t;
    logic [95:0]      noise;
    t.four_digit_year = 1'($urandom_range(0, 1));
    t.year_value  = t.four_digit_year ? 14'($urandom_range(1849, 2100))
                                      : 14'($urandom_range(0, 200));
    t.month       = 7'($urandom_range(1, 12));
    t.day         = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(29, 31))
                                                : 7'($urandom_range(1, 28));
    t.hour        = 7'($urandom_range(0, 23));
    t.minute      = 7'($urandom_range(0, 59));
    t.second      = 7'($urandom_range(0, 59));
    t.microsecond = 20'($urandom_range(0, 999999));
    if (!well_formed) begin
      noise = {$urandom, $urandom, $urandom};
      case ($urandom_range(0, 7))
        0: t.year_value  = noise[13:0];
        1: t.month       = noise[6:0];
        2: t.day         = noise[6:0];
        3: t.hour        = noise[6:0];
        4: t.minute      = noise[6:0];
        5: t.second      = noise[6:0];
        6: t.microsecond = noise[19:0];
        default: t = noise[$bits(dtm_pkg::dtm_in_t)-1:0];
      endcase
    end
    return t;
  endfunction

  // Offer one date-time and log its expected result on acceptance
  task automatic send_date_time(dtm_pkg::dtm_in_t t);
    in_ch.valid   <= 1'b1;
    in_ch.payload <= t;
    do @(posedge clk_i); while (!in_ch.ready);
    owed_mjd_results.push_back(mjd_of(t));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (owed_mjd_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write the epoch offset; call only while the pipe is empty
  task automatic write_epoch(epoch_t value);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    epoch_offset = $signed(value);
  endtask

  task automatic send_random_burst(int unsigned count);
    repeat (count) send_date_time(random_date_time($urandom_range(0, 9) != 0));
  endtask

  // Year pivots, month lengths, each range check and the microsecond clamp
  task automatic test_field_extremes();
    send_date_time(date_time(0,     0, 1,   1,   0,   0,   0,   0));
    send_date_time(date_time(1801,  1, 1,   1,   0,   0,   0,   0));
    send_date_time(date_time(2100,  1, 12,  31,  23,  59,  59,  999999));
    send_date_time(date_time(200,   0, 12,  31,  23,  59,  59,  0));
    send_date_time(date_time(201,   0, 6,   15,  12,  30,  30,  5));
    send_date_time(date_time(2101,  1, 6,   15,  12,  30,  30,  5));
    send_date_time(date_time(1800,  1, 6,   15,  12,  30,  30,  5));
    send_date_time(date_time(9999,  1, 6,   15,  12,  30,  30,  5));
    send_date_time(date_time(16383, 0, 127, 127, 127, 127, 127, 20'hFFFFF));
    send_date_time(date_time(49,    0, 3,   1,   0,   0,   0,   1));
    send_date_time(date_time(50,    0, 3,   1,   0,   0,   0,   1));
    send_date_time(date_time(1849,  1, 2,   28,  0,   0,   0,   1));
    send_date_time(date_time(1850,  1, 2,   28,  0,   0,   0,   1));
    send_date_time(date_time(1949,  1, 2,   28,  0,   0,   0,   1));
    send_date_time(date_time(23,    0, 2,   29,  6,   7,   8,   9));
    send_date_time(date_time(23,    0, 2,   30,  6,   7,   8,   9));
    send_date_time(date_time(23,    0, 0,   10,  6,   7,   8,   9));
    send_date_time(date_time(23,    0, 13,  0,   6,   7,   8,   9));
    send_date_time(date_time(23,    0, 4,   0,   6,   7,   8,   9));
    send_date_time(date_time(23,    0, 4,   31,  6,   7,   8,   9));
    send_date_time(date_time(23,    0, 4,   30,  6,   7,   8,   9));
    send_date_time(date_time(23,    0, 7,   4,   24,  7,   8,   9));
    send_date_time(date_time(23,    0, 7,   4,   23,  60,  8,   9));
    send_date_time(date_time(23,    0, 7,   4,   23,  59,  60,  9));
    send_date_time(date_time(23,    0, 7,   4,   23,  59,  59,  1000000));
    send_date_time(date_time(23,    0, 7,   4,   0,   0,   127, 20'hFFFFF));
    drain_results();
  endtask

  // Run traffic under the register extremes and a random offset
  task automatic test_epoch_settings();
    epoch_t settings[5];
    settings[0] = {1'b0, {(dtm_pkg::EpochW-1){1'b1}}};
    settings[1] = {1'b1, {(dtm_pkg::EpochW-1){1'b0}}};
    settings[2] = '1;
    settings[3] = epoch_t'({$urandom, $urandom});
    settings[4] = '0;
    foreach (settings[i]) begin
      write_epoch(settings[i]);
      send_random_burst(120);
      drain_results();
    end
  endtask

  // Hold the output off long enough to fill the pipe and stall the input
  task automatic test_output_holdoff();
    idle_on   = 1'b0;
    long_hold = 80;
    send_random_burst(48);
    drain_results();
    idle_on = 1'b1;
  endtask

  // Random traffic with idling switched on and off per stretch
  task automatic test_random_stream();
    write_epoch(epoch_t'({$urandom, $urandom}));
    repeat (8) begin
      idle_on = ($urandom_range(0, 3) != 0);
      send_random_burst(100);
    end
    drain_results();
  endtask

  // Back-to-back traffic with both sides always ready
  task automatic test_steady_stream();
    idle_on = 1'b0;
    send_random_burst(100);
    drain_results();
  endtask

  // Output side: random stalls plus an occasional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
      end else if (long_hold != 0) begin
        stall_left = long_hold;
        long_hold  = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  // Compare every transaction on the output with the oldest expectation
  always @(posedge clk_i) begin
    dtm_pkg::dtm_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (owed_mjd_results.size() == 0) begin
        $display("%0t: result with nothing expected: total %0d us %0d status %0d",
                 $time, $signed(out_ch.payload.total_seconds),
                 out_ch.payload.sub_second, out_ch.payload.status);
        mismatches++;
      end else begin
        want = owed_mjd_results.pop_front();
        if (out_ch.payload.total_seconds !== want.total_seconds) begin
          $display("%0t: total_seconds expected %0d actual %0d", $time,
                   $signed(want.total_seconds), $signed(out_ch.payload.total_seconds));
          mismatches++;
        end
        if (out_ch.payload.sub_second !== want.sub_second) begin
          $display("%0t: sub_second expected %0d actual %0d", $time,
                   want.sub_second, out_ch.payload.sub_second);
          mismatches++;
        end
        if (out_ch.payload.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_ch.payload.status);
          mismatches++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    idle_on        = 1'b1;
    long_hold      = 0;
    epoch_offset   = 0;
    mismatches     = 0;
    cycle_count    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_epoch_settings();
    test_output_holdoff();
    test_random_stream();
    test_steady_stream();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
